// File: design/deq_pkg.sv
package deq_pkg;

   localparam int DEPTH = 128;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OP_W = 3;
   localparam int BYTE_W = 8;
   localparam int STATUS_W = 2;

   localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'd48;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_PEEK_FRONT = 3'd2,
      OP_PEEK_BACK  = 3'd3,
      OP_POP_FRONT  = 3'd4,
      OP_POP_BACK   = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_SHIFT_IN  = 2'd1,
      CELL_SHIFT_OUT = 2'd2,
      CELL_WRITE     = 2'd3
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type     mode;
      logic [CNT_W-1:0]  count;
      logic [BYTE_W-1:0] data;
   } cell_ctrl_type;

endpackage

// File: design/deq_if.sv
interface deq_req_if;
   logic                          valid;
   logic                          ready;
   logic [deq_pkg::OP_W-1:0]      operation;
   logic [deq_pkg::BYTE_W-1:0]    push_byte;

   modport source (output valid, output operation, output push_byte, input ready);
   modport sink (input valid, input operation, input push_byte, output ready);
endinterface

interface deq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [deq_pkg::BYTE_W-1:0]    out_byte;
   logic [deq_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output out_byte, output status, input ready);
   modport sink (input valid, input out_byte, input status, output ready);
endinterface

// File: design/deq_cell.sv
module deq_cell (
   input  logic                           clock,
   input  deq_pkg::cell_ctrl_type         ctrl,
   input  logic [deq_pkg::IDX_W-1:0]      cell_index,
   input  logic [deq_pkg::BYTE_W-1:0]     left_byte,
   input  logic [deq_pkg::BYTE_W-1:0]     right_byte,
   output logic [deq_pkg::BYTE_W-1:0]     cell_byte
);
   import deq_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   always_comb begin
      unique case (ctrl.mode)
         CELL_SHIFT_IN:  byte_in = left_byte;
         CELL_SHIFT_OUT: byte_in = right_byte;
         CELL_WRITE:     byte_in = (CNT_W'(cell_index) == ctrl.count) ? ctrl.data : byte_ff;
         default:        byte_in = byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

// File: design/deq_chain.sv
module deq_chain (
   input  logic                        clock,
   input  deq_pkg::cell_ctrl_type      ctrl,
   output logic [deq_pkg::BYTE_W-1:0]  head_byte
);
   import deq_pkg::*;

   logic [BYTE_W-1:0] chain_byte [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [BYTE_W-1:0] left_byte;
      logic [BYTE_W-1:0] right_byte;

      if (i == 0) begin : g_first
         assign left_byte = ctrl.data;
      end else begin : g_inner_left
         assign left_byte = chain_byte[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_byte = chain_byte[i];
      end else begin : g_inner_right
         assign right_byte = chain_byte[i+1];
      end

      deq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (IDX_W'(i)),
         .left_byte  (left_byte),
         .right_byte (right_byte),
         .cell_byte  (chain_byte[i])
      );
   end

   assign head_byte = chain_byte[0];

endmodule

// File: design/double_ended_queue.sv
// A request's response is registered and appears in the cycle after acceptance.
// One request per cycle is taken outside reset; the output register holds back input only while
// an earlier response is stalled.
// Two chains of cells hold the queue, one with the front at cell 0 and one with the back
// at cell 0, so every operation touches only a fixed end or a decoded cell.
// Reset empties the queue and drops any pending response; cell contents are not cleared.
module double_ended_queue (
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req_if,
   deq_rsp_if.source  rsp_if
);
   import deq_pkg::*;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic [BYTE_W-1:0]   rsp_byte_in;
   status_type          rsp_status_ff;
   status_type          rsp_status_in;
   logic                accept;
   logic                full;
   logic                empty;
   cell_ctrl_type       front_ctrl;
   cell_ctrl_type       back_ctrl;
   logic [BYTE_W-1:0]   front_head;
   logic [BYTE_W-1:0]   back_head;

   assign req_if.ready = !reset && (!rsp_valid_ff || rsp_if.ready);
   assign accept = req_if.valid && req_if.ready;
   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      front_ctrl.mode = CELL_HOLD;
      front_ctrl.count = count_ff;
      front_ctrl.data = req_if.push_byte;
      back_ctrl.mode = CELL_HOLD;
      back_ctrl.count = count_ff;
      back_ctrl.data = req_if.push_byte;
      count_in = count_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_byte_in = '0;
         rsp_status_in = ST_OK;
         unique case (opcode_type'(req_if.operation))
            OP_PUSH_FRONT: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  front_ctrl.mode = CELL_SHIFT_IN;
                  back_ctrl.mode = CELL_WRITE;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  front_ctrl.mode = CELL_WRITE;
                  back_ctrl.mode = CELL_SHIFT_IN;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_PEEK_FRONT, OP_POP_FRONT: begin
               if (empty) begin
                  rsp_byte_in = EMPTY_BYTE;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_byte_in = front_head;
                  if (opcode_type'(req_if.operation) == OP_POP_FRONT) begin
                     front_ctrl.mode = CELL_SHIFT_OUT;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            OP_PEEK_BACK, OP_POP_BACK: begin
               if (empty) begin
                  rsp_byte_in = EMPTY_BYTE;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_byte_in = back_head;
                  if (opcode_type'(req_if.operation) == OP_POP_BACK) begin
                     back_ctrl.mode = CELL_SHIFT_OUT;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               rsp_byte_in = '0;
               rsp_status_in = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
   end

   deq_chain u_front_chain (
      .clock     (clock),
      .ctrl      (front_ctrl),
      .head_byte (front_head)
   );

   deq_chain u_back_chain (
      .clock     (clock),
      .ctrl      (back_ctrl),
      .head_byte (back_head)
   );

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.out_byte = rsp_byte_ff;
   assign rsp_if.status = rsp_status_ff;

`ifndef ASSERT_OFF
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Entry count exceeds the queue depth.");

   a_full_push : assert property (@(posedge clock) disable iff (reset)
      accept && full && (req_if.operation == OP_PUSH_FRONT || req_if.operation == OP_PUSH_BACK)
      |=> rsp_status_ff == ST_FULL && $stable(count_ff))
      else $error("A push on a full queue changed the count or was not reported full.");

   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      accept && !empty && (req_if.operation == OP_POP_FRONT || req_if.operation == OP_POP_BACK)
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("A pop on a nonempty queue did not remove exactly one entry.");

   a_rsp_follows : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("An accepted request produced no response.");
`endif

endmodule
